// ===== hw/rtl/sed_pkg.sv =====
// ----------------------------------------------------------------------------
// sed_pkg
// Shared types, character codes and helper functions for the escape decoder.
// ----------------------------------------------------------------------------
package sed_pkg;

  localparam int unsigned QDEPTH = 4;
  localparam int unsigned QPTR_W = $clog2(QDEPTH);
  localparam int unsigned QCNT_W = $clog2(QDEPTH + 1);

  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_X      = 8'h78;
  localparam logic [7:0] CH_0      = 8'h30;
  localparam logic [7:0] CH_7      = 8'h37;
  localparam logic [7:0] CH_9      = 8'h39;
  localparam logic [7:0] CH_LA     = 8'h61;
  localparam logic [7:0] CH_LF     = 8'h66;
  localparam logic [7:0] CH_UA     = 8'h41;
  localparam logic [7:0] CH_UF     = 8'h46;
  localparam logic [7:0] CH_N      = 8'h6E;
  localparam logic [7:0] CH_T      = 8'h74;
  localparam logic [7:0] CH_R      = 8'h72;
  localparam logic [7:0] CH_V      = 8'h76;
  localparam logic [7:0] CH_B      = 8'h62;
  localparam logic [7:0] CH_F      = 8'h66;
  localparam logic [7:0] CH_A      = 8'h61;

  localparam logic [4:0] HEX_BAD = 5'h10;

  typedef enum logic [1:0] {
    KIND_BYTE = 2'd0,
    KIND_DONE = 2'd1,
    KIND_BAD  = 2'd2
  } kind_e;

  typedef struct packed {
    logic [7:0] data;
    kind_e      kind;
  } res_t;

  // One queue entry holds every result of one input beat.
  typedef struct packed {
    res_t res0;
    res_t res1;
    logic two;
  } q_entry_t;

  typedef struct packed {
    logic empty;
    logic full;
  } q_status_t;

  function automatic logic [4:0] hex_digit(input logic [7:0] c);
    logic [4:0] v;
    v = HEX_BAD;
    if (c >= CH_0 && c <= CH_9) v = 5'(c - CH_0);
    else if (c >= CH_LA && c <= CH_LF) v = 5'(c - CH_LA + 8'd10);
    else if (c >= CH_UA && c <= CH_UF) v = 5'(c - CH_UA + 8'd10);
    return v;
  endfunction

  function automatic logic is_octal(input logic [7:0] c);
    return (c >= CH_0) && (c <= CH_7);
  endfunction

  function automatic logic [7:0] escape_byte(input logic [7:0] c);
    logic [7:0] v;
    unique case (c)
      CH_N:    v = 8'd10;
      CH_T:    v = 8'd9;
      CH_R:    v = 8'd13;
      CH_V:    v = 8'd11;
      CH_B:    v = 8'd8;
      CH_F:    v = 8'd12;
      CH_A:    v = 8'd7;
      default: v = c;
    endcase
    return v;
  endfunction

endpackage

// ===== hw/rtl/sed_front.sv =====
// ----------------------------------------------------------------------------
// sed_front
// Accepts literal characters, tracks escape state and builds one queue entry
// with the zero, one or two results each beat gives.
// ----------------------------------------------------------------------------
module sed_front import sed_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic [7:0] char_in_i,
  input  logic       end_of_literal_i,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  q_status_t  q_status_i,
  output logic       push_o,
  output q_entry_t   push_data_o
);

  typedef enum logic [5:0] {
    MODE_IDLE = 6'b000001,
    MODE_ESC  = 6'b000010,
    MODE_HEX1 = 6'b000100,
    MODE_HEX2 = 6'b001000,
    MODE_OCT  = 6'b010000,
    MODE_BAD  = 6'b100000
  } mode_e;

  mode_e      mode_q, mode_d;
  logic [7:0] oct_val_q, oct_val_d;
  logic [1:0] oct_cnt_q, oct_cnt_d;
  logic [4:0] hex_hi_q, hex_hi_d;

  logic       accept;
  logic [4:0] hex_lo;
  logic [7:0] oct_next;
  res_t       r0, r1;
  logic       n0, n1;

  assign in_stall_o = q_status_i.full;
  assign accept     = in_valid_i && !q_status_i.full;
  assign hex_lo     = hex_digit(char_in_i);
  assign oct_next   = {oct_val_q[4:0], 3'(char_in_i - CH_0)};

  always_comb begin
    mode_d    = mode_q;
    oct_val_d = oct_val_q;
    oct_cnt_d = oct_cnt_q;
    hex_hi_d  = hex_hi_q;
    r0        = '{data: 8'd0, kind: KIND_BYTE};
    r1        = '{data: 8'd0, kind: KIND_BYTE};
    n0        = 1'b0;
    n1        = 1'b0;
    if (end_of_literal_i) begin
      unique case (mode_q)
        MODE_IDLE: begin
          r0 = '{data: 8'd0, kind: KIND_DONE};
          n0 = 1'b1;
        end
        MODE_OCT: begin
          r0 = '{data: oct_val_q, kind: KIND_BYTE};
          r1 = '{data: 8'd0, kind: KIND_DONE};
          n0 = 1'b1;
          n1 = 1'b1;
        end
        default: begin
          r0 = '{data: 8'd0, kind: KIND_BAD};
          n0 = 1'b1;
        end
      endcase
      mode_d    = MODE_IDLE;
      oct_val_d = 8'd0;
      oct_cnt_d = 2'd0;
      hex_hi_d  = 5'd0;
    end else begin
      unique case (mode_q)
        MODE_IDLE: begin
          if (char_in_i == CH_BSLASH) begin
            mode_d = MODE_ESC;
          end else begin
            r0 = '{data: char_in_i, kind: KIND_BYTE};
            n0 = 1'b1;
          end
        end
        MODE_ESC: begin
          if (char_in_i == CH_X) begin
            mode_d = MODE_HEX1;
          end else if (is_octal(char_in_i)) begin
            oct_val_d = char_in_i - CH_0;
            oct_cnt_d = 2'd1;
            mode_d    = MODE_OCT;
          end else begin
            r0     = '{data: escape_byte(char_in_i), kind: KIND_BYTE};
            n0     = 1'b1;
            mode_d = MODE_IDLE;
          end
        end
        MODE_HEX1: begin
          hex_hi_d = hex_lo[4] ? HEX_BAD : hex_lo;
          mode_d   = MODE_HEX2;
        end
        MODE_HEX2: begin
          if (hex_hi_q[4] || hex_lo[4]) begin
            mode_d = MODE_BAD;
          end else begin
            r0     = '{data: {hex_hi_q[3:0], hex_lo[3:0]}, kind: KIND_BYTE};
            n0     = 1'b1;
            mode_d = MODE_IDLE;
          end
          hex_hi_d = 5'd0;
        end
        MODE_OCT: begin
          if (is_octal(char_in_i)) begin
            if (oct_cnt_q >= 2'd2) begin
              r0        = '{data: oct_next, kind: KIND_BYTE};
              n0        = 1'b1;
              oct_val_d = 8'd0;
              oct_cnt_d = 2'd0;
              mode_d    = MODE_IDLE;
            end else begin
              oct_val_d = oct_next;
              oct_cnt_d = oct_cnt_q + 2'd1;
            end
          end else begin
            // flush the pending value, then handle the character as in idle mode
            r0        = '{data: oct_val_q, kind: KIND_BYTE};
            n0        = 1'b1;
            oct_val_d = 8'd0;
            oct_cnt_d = 2'd0;
            if (char_in_i == CH_BSLASH) begin
              mode_d = MODE_ESC;
            end else begin
              r1     = '{data: char_in_i, kind: KIND_BYTE};
              n1     = 1'b1;
              mode_d = MODE_IDLE;
            end
          end
        end
        default: mode_d = MODE_BAD;
      endcase
    end
  end

  assign push_o      = accept && n0;
  assign push_data_o = '{res0: r0, res1: r1, two: n1};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q    <= MODE_IDLE;
      oct_val_q <= 8'd0;
      oct_cnt_q <= 2'd0;
      hex_hi_q  <= 5'd0;
    end else if (accept) begin
      mode_q    <= mode_d;
      oct_val_q <= oct_val_d;
      oct_cnt_q <= oct_cnt_d;
      hex_hi_q  <= hex_hi_d;
    end
  end

endmodule

// ===== hw/rtl/sed_fifo.sv =====
// ----------------------------------------------------------------------------
// sed_fifo
// Short queue of result entries between the front and the back.
// ----------------------------------------------------------------------------
module sed_fifo import sed_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      push_i,
  input  q_entry_t  push_data_i,
  input  logic      pop_i,
  output q_entry_t  head_o,
  output q_status_t status_o
);

  q_entry_t          mem_q [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr_q, rd_ptr_q;
  logic [QCNT_W-1:0] cnt_q;
  logic              do_push, do_pop;

  assign status_o.empty = (cnt_q == '0);
  assign status_o.full  = (cnt_q == QCNT_W'(QDEPTH));
  assign do_push        = push_i && !status_o.full;
  assign do_pop         = pop_i && !status_o.empty;
  assign head_o         = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (do_push) wr_ptr_q <= wr_ptr_q + 1'b1;
      if (do_pop)  rd_ptr_q <= rd_ptr_q + 1'b1;
      unique case ({do_push, do_pop})
        2'b10:   cnt_q <= cnt_q + 1'b1;
        2'b01:   cnt_q <= cnt_q - 1'b1;
        default: cnt_q <= cnt_q;
      endcase
    end
  end

endmodule

// ===== hw/rtl/sed_back.sv =====
// ----------------------------------------------------------------------------
// sed_back
// Unpacks queue entries into single result beats behind an output register.
// ----------------------------------------------------------------------------
module sed_back import sed_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  q_entry_t   head_i,
  input  q_status_t  q_status_i,
  output logic       pop_o,
  output logic [7:0] out_byte_o,
  output logic [1:0] kind_o,
  output logic       last_o,
  output logic       out_valid_o,
  input  logic       out_stall_i
);

  logic       valid_q;
  logic [7:0] byte_q;
  kind_e      kind_q;
  logic       last_q;
  logic       sub_q, sub_d;
  logic       load;
  res_t       cur;
  logic       cur_last;

  assign load     = (!valid_q || !out_stall_i) && !q_status_i.empty;
  assign cur      = sub_q ? head_i.res1 : head_i.res0;
  assign cur_last = sub_q || !head_i.two;
  assign pop_o    = load && cur_last;
  assign sub_d    = load ? !cur_last : sub_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      sub_q   <= 1'b0;
    end else begin
      sub_q <= sub_d;
      if (load) begin
        valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        valid_q <= 1'b0;
      end
    end
  end

  // hold payload while stalled
  always_ff @(posedge clk_i) begin
    if (load) begin
      byte_q <= cur.data;
      kind_q <= cur.kind;
      last_q <= cur_last;
    end
  end

  assign out_valid_o = valid_q;
  assign out_byte_o  = byte_q;
  assign kind_o      = kind_q;
  assign last_o      = last_q;

endmodule

// ===== hw/rtl/string_escape_decoder.sv =====
// ----------------------------------------------------------------------------
// string_escape_decoder
// An accepted character's results enter the queue, then the output register.
// Throughput: one character per cycle while the queue is not full;
// a two-result beat leaves as two beats, paced by the single output register.
// A four-entry queue separates the decoding front from the output back.
// Reset clears the escape state, the queue and the output valid at once.
// ----------------------------------------------------------------------------
module string_escape_decoder import sed_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic [7:0] char_in_i,
  input  logic       end_of_literal_i,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  output logic [7:0] out_byte_o,
  output logic [1:0] kind_o,
  output logic       last_o,
  output logic       out_valid_o,
  input  logic       out_stall_i
);

  logic      push, pop;
  q_entry_t  push_data, head;
  q_status_t q_status;

  sed_front u_front (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .char_in_i        (char_in_i),
    .end_of_literal_i (end_of_literal_i),
    .in_valid_i       (in_valid_i),
    .in_stall_o       (in_stall_o),
    .q_status_i       (q_status),
    .push_o           (push),
    .push_data_o      (push_data)
  );

  sed_fifo u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_data),
    .pop_i       (pop),
    .head_o      (head),
    .status_o    (q_status)
  );

  sed_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .head_i      (head),
    .q_status_i  (q_status),
    .pop_o       (pop),
    .out_byte_o  (out_byte_o),
    .kind_o      (kind_o),
    .last_o      (last_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i)
  );

endmodule
